FILE: hdl/owt_pkg.sv
package owt_pkg;

  // Default window limit and depth of the queue between front and back.
  localparam int unsigned MAX_SAMPLES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned SAMPLE_W        = 8;
  localparam logic [SAMPLE_W-1:0] TOP_CANDIDATE = 8'd255;
  localparam logic [SAMPLE_W-1:0] FIRST_CANDIDATE = 8'd1;

  // One classified sample beat as it travels from front to back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                counted;
    logic                last;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC,
    ST_PRIME,
    ST_ACC,
    ST_DIFF,
    ST_SQ,
    ST_M0,
    ST_M1,
    ST_CMP,
    ST_OUT
  } back_state_e;

endpackage

FILE: hdl/owt_front.sv
module owt_front #(
  parameter int unsigned MaxSamples = owt_pkg::MAX_SAMPLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [owt_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         last_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output owt_pkg::item_t               q_item_o
);

  localparam int unsigned CntW = $clog2(MaxSamples + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            room;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CntW'(MaxSamples));

  // Mark beats beyond the window limit so the back end drops them.
  assign q_push_o         = accept;
  assign q_item_o.sample  = sample_i;
  assign q_item_o.counted = room;
  assign q_item_o.last    = last_i;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (room) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/owt_queue.sv
module owt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  owt_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           ready_i,
  output owt_pkg::item_t item_o
);

  localparam int unsigned Depth = owt_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(Depth);

  owt_pkg::item_t mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AW:0]    fill_q, fill_d;
  logic           pop;

  assign full_o  = (fill_q == (AW + 1)'(Depth));
  assign valid_o = (fill_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop) begin
      fill_d = fill_q + (AW + 1)'(1);
    end else if (pop && !push_i) begin
      fill_d = fill_q - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: hdl/owt_back.sv
module owt_back #(
  parameter int unsigned MaxSamples = owt_pkg::MAX_SAMPLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  owt_pkg::item_t               q_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [owt_pkg::SAMPLE_W-1:0] threshold_o
);

  localparam int unsigned SW    = owt_pkg::SAMPLE_W;
  localparam int unsigned Bins  = 1 << SW;
  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned SumW  = CntW + SW;
  localparam int unsigned NnW   = 2 * CntW;
  localparam int unsigned SqW   = 2 * SumW;
  localparam int unsigned HalfW = SumW;
  localparam int unsigned PW    = NnW + HalfW;
  localparam int unsigned ScW   = NnW + SqW;

  owt_pkg::back_state_e state_q, state_d;

  // Histogram store; an entry whose valid bit is clear reads as zero.
  logic [CntW-1:0] hist_q [Bins];
  logic [Bins-1:0] vld_q, vld_d;
  logic [CntW-1:0] rd_q;
  logic            rd_vld_q;
  logic            re;
  logic [SW-1:0]   ra;
  logic            we;
  logic [CntW-1:0] wd;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SW-1:0]   smp_q, smp_d;
  logic            last_q, last_d;

  logic [SW-1:0]   t_q, t_d;
  logic [CntW-1:0] low_n_q, low_n_d;
  logic [SumW-1:0] low_s_q, low_s_d;
  logic [NnW-1:0]  nn_q, nn_d;
  logic [SumW-1:0] diff_q, diff_d;
  logic [SqW-1:0]  sq_q, sq_d;
  logic [PW-1:0]   part_q, part_d;
  logic [ScW-1:0]  score_q, score_d;
  logic [ScW-1:0]  best_q, best_d;
  logic [SW-1:0]   best_t_q, best_t_d;

  logic            out_valid_q, out_valid_d;
  logic [SW-1:0]   thr_q, thr_d;
  logic            load_out;

  logic [CntW-1:0] h;
  logic [SumW-1:0] h_t;
  logic [CntW-1:0] high_n;
  logic [SumW-1:0] high_s;
  logic [PW-1:0]   hi_prod;

  assign h       = rd_vld_q ? rd_q : '0;
  assign h_t     = {{SW{1'b0}}, h} * {{CntW{1'b0}}, t_q};
  assign high_n  = cnt_q - low_n_q;
  assign high_s  = sum_q - low_s_q;
  assign hi_prod = {{HalfW{1'b0}}, nn_q} * {{NnW{1'b0}}, sq_q[SqW-1:HalfW]};

  assign q_ready_o   = (state_q == owt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign threshold_o = thr_q;
  assign load_out    = (state_q == owt_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    vld_d    = vld_q;
    re       = 1'b0;
    ra       = t_q + SW'(1);
    we       = 1'b0;
    wd       = h + CntW'(1);
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    smp_d    = smp_q;
    last_d   = last_q;
    t_d      = t_q;
    low_n_d  = low_n_q;
    low_s_d  = low_s_q;
    nn_d     = nn_q;
    diff_d   = diff_q;
    sq_d     = sq_q;
    part_d   = part_q;
    score_d  = score_q;
    best_d   = best_q;
    best_t_d = best_t_q;
    unique case (state_q)
      owt_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          smp_d  = q_item_i.sample;
          last_d = q_item_i.last;
          if (q_item_i.counted) begin
            re      = 1'b1;
            ra      = q_item_i.sample;
            state_d = owt_pkg::ST_INC;
          end else if (q_item_i.last) begin
            state_d = owt_pkg::ST_PRIME;
          end
        end
      end
      owt_pkg::ST_INC: begin
        we           = 1'b1;
        vld_d[smp_q] = 1'b1;
        cnt_d        = cnt_q + CntW'(1);
        sum_d        = sum_q + SumW'(smp_q);
        state_d      = last_q ? owt_pkg::ST_PRIME : owt_pkg::ST_IDLE;
      end
      owt_pkg::ST_PRIME: begin
        re      = 1'b1;
        ra      = '0;
        t_d     = '0;
        low_n_d = '0;
        low_s_d = '0;
        state_d = owt_pkg::ST_ACC;
      end
      owt_pkg::ST_ACC: begin
        // fold in bin t and fetch bin t+1 for the next candidate
        re      = 1'b1;
        low_n_d = low_n_q + h;
        low_s_d = low_s_q + h_t;
        if (t_q == '0) begin
          t_d = owt_pkg::FIRST_CANDIDATE;
        end else begin
          state_d = owt_pkg::ST_DIFF;
        end
      end
      owt_pkg::ST_DIFF: begin
        nn_d    = {{CntW{1'b0}}, high_n} * {{CntW{1'b0}}, low_n_q};
        diff_d  = (low_s_q >= high_s) ? low_s_q - high_s : high_s - low_s_q;
        state_d = owt_pkg::ST_SQ;
      end
      owt_pkg::ST_SQ: begin
        sq_d    = {{SumW{1'b0}}, diff_q} * {{SumW{1'b0}}, diff_q};
        state_d = owt_pkg::ST_M0;
      end
      owt_pkg::ST_M0: begin
        part_d  = {{HalfW{1'b0}}, nn_q} * {{NnW{1'b0}}, sq_q[HalfW-1:0]};
        state_d = owt_pkg::ST_M1;
      end
      owt_pkg::ST_M1: begin
        score_d = ScW'(part_q) + (ScW'(hi_prod) << HalfW);
        state_d = owt_pkg::ST_CMP;
      end
      owt_pkg::ST_CMP: begin
        if (t_q == owt_pkg::FIRST_CANDIDATE || score_q > best_q) begin
          best_d   = score_q;
          best_t_d = t_q;
        end
        if (t_q == owt_pkg::TOP_CANDIDATE) begin
          state_d = owt_pkg::ST_OUT;
        end else begin
          t_d     = t_q + SW'(1);
          state_d = owt_pkg::ST_ACC;
        end
      end
      owt_pkg::ST_OUT: begin
        if (load_out) begin
          vld_d   = '0;
          cnt_d   = '0;
          sum_d   = '0;
          state_d = owt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = owt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    thr_d       = thr_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      thr_d       = best_t_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= owt_pkg::ST_IDLE;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (re) begin
        rd_vld_q <= vld_q[ra];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      hist_q[smp_q] <= wd;
    end
    if (re) begin
      rd_q <= hist_q[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q    <= smp_d;
    last_q   <= last_d;
    t_q      <= t_d;
    low_n_q  <= low_n_d;
    low_s_q  <= low_s_d;
    nn_q     <= nn_d;
    diff_q   <= diff_d;
    sq_q     <= sq_d;
    part_q   <= part_d;
    score_q  <= score_d;
    best_q   <= best_d;
    best_t_q <= best_t_d;
    thr_q    <= thr_d;
  end

endmodule

FILE: hdl/otsu_window_threshold.sv
// Window threshold search: finds the between-class best threshold of a window.
// Input channel: in_valid_i/in_ready_o with sample_i and last_i; last_i marks
//   the final beat of a window. Beats past MaxSamples in one window are
//   dropped, but a last mark on a dropped beat still closes the window.
// Output channel: out_valid_o/out_ready_i with threshold_o, one beat per window.
// Front end takes one beat per cycle, while the 4-entry queue has room; the
//   back end reads the histogram bin of a counted sample, then writes it back,
//   skips both for a dropped beat, and takes a new beat only when idle.
// After the last beat leaves the queue the back end sweeps all 255 candidate
//   thresholds: it primes with bin 0, then runs each candidate through the
//   shared subtract/multiply chain (accumulate, difference, square, the score
//   product as two partial multiplies, compare), then loads threshold_o.
// Throughput per window is set by that sweep plus each counted sample's update.
// Reset clears the queue, all histogram valid bits, the counters and the
//   output valid flag; the block is ready in the first cycle after reset.
// A stalled receiver holds the result in the output register; the back end
//   keeps counting the next window's samples meanwhile and waits only when a
//   second result is ready to load.
module otsu_window_threshold #(
  parameter int unsigned MaxSamples = owt_pkg::MAX_SAMPLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [owt_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [owt_pkg::SAMPLE_W-1:0] threshold_o
);

  owt_pkg::item_t push_item;
  owt_pkg::item_t pop_item;
  logic           push;
  logic           full;
  logic           pop_valid;
  logic           pop_ready;

  // Classify each beat as counted or dropped.
  owt_front #(
    .MaxSamples(MaxSamples)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i  (sample_i),
    .last_i    (last_i),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_item_o  (push_item)
  );

  // Decouple the front from the histogram and sweep engine.
  owt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .valid_o(pop_valid),
    .ready_i(pop_ready),
    .item_o (pop_item)
  );

  // Build the histogram, sweep candidates and hold the result.
  owt_back #(
    .MaxSamples(MaxSamples)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (pop_valid),
    .q_ready_o  (pop_ready),
    .q_item_i   (pop_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .threshold_o(threshold_o)
  );

endmodule
